>>> rtl/ais_hdlc_frame_encoder_assert.svh
// assertion macros for the ais hdlc frame encoder
`ifndef AIS_HDLC_FRAME_ENCODER_ASSERT_SVH
`define AIS_HDLC_FRAME_ENCODER_ASSERT_SVH

`ifndef SYNTHESIS

// clocked check, held off while reset is asserted
`define AHE_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("ais_hdlc_frame_encoder check failed");

// clocked check that also holds during reset
`define AHE_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("ais_hdlc_frame_encoder check failed");

`else

`define AHE_ASSERT(lbl, clk, rstn, prop)
`define AHE_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

>>> rtl/aishdlc_pkg.sv
package aishdlc_pkg;

  // frame constants
  localparam int unsigned PayloadBytesDef = 21;
  localparam logic [31:0] Preamble        = 32'hCCCC_CCFE;
  localparam logic [7:0]  EndFlag         = 8'hFE;
  localparam logic [15:0] CrcPoly         = 16'h8408;
  localparam logic [15:0] CrcInit         = 16'hFFFF;
  localparam int unsigned StuffRun        = 5;

  // phase lengths in source bits
  localparam int unsigned PreBits  = 32;
  localparam int unsigned DataBits = 8;
  localparam int unsigned CrcBits  = 16;
  localparam int unsigned FlagBits = 8;

  // sequencer states
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_PRE  = 5'b00010,
    ST_DATA = 5'b00100,
    ST_CRC  = 5'b01000,
    ST_FLAG = 5'b10000
  } state_e;

endpackage

>>> rtl/ais_hdlc_frame_encoder.sv
// ais hdlc frame encoder
// Input channel: payload_byte_i with in_valid_i / in_stall_o. A request is
// taken when in_valid_i is high and in_stall_o is low; in_stall_o stays high
// while a byte is being serialized.
// Output channel: one line bit per transfer on line_bit_o, with run_last_o on
// the last bit a byte causes and frame_end_o on the final end-flag bit.
// Throughput: one line bit per cycle while a byte is serialized and the receiver
// does not stall, from a single bit-serial unit (crc step, stuffing counter, nrzi
// level). A byte is taken while idle, then sent as its data bits and stuffed zeros;
// the first byte of a frame adds the preamble bits, the last adds the crc bits with
// their stuffed zeros and the end-flag bits. The first bit is held in the output register.
// Reset clears the frame: byte count 0, crc 0xFFFF, run count 0, level 0.
// When the receiver stalls, the output register holds its bit and the
// sequencer waits; no bit is lost or repeated.
module ais_hdlc_frame_encoder #(
  parameter int unsigned PAYLOAD_BYTES = aishdlc_pkg::PayloadBytesDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] payload_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       line_bit_o,
  output logic       run_last_o,
  output logic       frame_end_o
);

`include "ais_hdlc_frame_encoder_assert.svh"

  localparam int unsigned BcW = $clog2(PAYLOAD_BYTES + 1);

  aishdlc_pkg::state_e state_q, state_d;
  logic [4:0]     cnt_q, cnt_d;
  logic [BcW-1:0] bc_q, bc_d;
  logic [15:0]    crc_q, crc_d;
  logic [2:0]     ones_q, ones_d;
  logic           lvl_q, lvl_d;
  logic           stuff_q, stuff_d;
  logic [7:0]     byte_q, byte_d;
  logic           ovalid_q, ovalid_d;
  logic           line_q, line_d;
  logic           last_q, last_d;
  logic           fend_q, fend_d;

  logic in_acc;
  logic advance;
  logic dbit;
  logic fb;

  // handshake
  assign in_stall_o = (state_q != aishdlc_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign advance    = (state_q != aishdlc_pkg::ST_IDLE) && (!ovalid_q || !out_stall_i);

  // sequencer and bit-serial unit
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    bc_d     = bc_q;
    crc_d    = crc_q;
    ones_d   = ones_q;
    lvl_d    = lvl_q;
    stuff_d  = stuff_q;
    byte_d   = byte_q;
    line_d   = line_q;
    last_d   = last_q;
    fend_d   = fend_q;
    ovalid_d = ovalid_q;
    dbit     = 1'b0;
    fb       = 1'b0;

    if (ovalid_q && !out_stall_i) begin
      ovalid_d = 1'b0;
    end

    if (in_acc) begin
      byte_d  = payload_byte_i;
      cnt_d   = '0;
      state_d = (bc_q == '0) ? aishdlc_pkg::ST_PRE : aishdlc_pkg::ST_DATA;
    end

    if (advance) begin
      ovalid_d = 1'b1;
      last_d   = 1'b0;
      fend_d   = 1'b0;
      unique case (state_q)
        aishdlc_pkg::ST_PRE: begin
          line_d = aishdlc_pkg::Preamble[~cnt_q];
          if (cnt_q == 5'(aishdlc_pkg::PreBits - 1)) begin
            cnt_d   = '0;
            state_d = aishdlc_pkg::ST_DATA;
          end else begin
            cnt_d = cnt_q + 5'd1;
          end
        end
        aishdlc_pkg::ST_DATA, aishdlc_pkg::ST_CRC: begin
          if (stuff_q) begin
            // inserted zero after a run of ones
            dbit    = 1'b0;
            stuff_d = 1'b0;
            ones_d  = '0;
          end else begin
            if (state_q == aishdlc_pkg::ST_DATA) begin
              dbit  = byte_q[cnt_q[2:0]];
              fb    = crc_q[0] ^ dbit;
              crc_d = (crc_q >> 1) ^ (fb ? aishdlc_pkg::CrcPoly : 16'h0000);
            end else begin
              dbit = ~crc_q[cnt_q[3:0]];
            end
            ones_d = dbit ? ones_q + 3'd1 : 3'd0;
            if (dbit && (ones_q == 3'(aishdlc_pkg::StuffRun - 1))) begin
              stuff_d = 1'b1;
              ones_d  = '0;
            end
            cnt_d = cnt_q + 5'd1;
          end
          // nrzi: zero toggles the level
          lvl_d  = lvl_q ^ ~dbit;
          line_d = lvl_d;
          // phase end once all bits and any pending stuff bit are out
          if (!stuff_d && (state_q == aishdlc_pkg::ST_DATA)
              && (cnt_d == 5'(aishdlc_pkg::DataBits))) begin
            cnt_d = '0;
            bc_d  = bc_q + BcW'(1);
            if (bc_q + BcW'(1) == BcW'(PAYLOAD_BYTES)) begin
              state_d = aishdlc_pkg::ST_CRC;
            end else begin
              state_d = aishdlc_pkg::ST_IDLE;
              last_d  = 1'b1;
            end
          end else if (!stuff_d && (state_q == aishdlc_pkg::ST_CRC)
                       && (cnt_d == 5'(aishdlc_pkg::CrcBits))) begin
            cnt_d   = '0;
            state_d = aishdlc_pkg::ST_FLAG;
          end
        end
        aishdlc_pkg::ST_FLAG: begin
          line_d = aishdlc_pkg::EndFlag[~cnt_q[2:0]];
          if (cnt_q == 5'(aishdlc_pkg::FlagBits - 1)) begin
            // frame done, back to reset values
            last_d  = 1'b1;
            fend_d  = 1'b1;
            state_d = aishdlc_pkg::ST_IDLE;
            cnt_d   = '0;
            bc_d    = '0;
            crc_d   = aishdlc_pkg::CrcInit;
            ones_d  = '0;
            lvl_d   = 1'b0;
          end else begin
            cnt_d = cnt_q + 5'd1;
          end
        end
        default: begin
          state_d = aishdlc_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= aishdlc_pkg::ST_IDLE;
      cnt_q    <= '0;
      bc_q     <= '0;
      crc_q    <= aishdlc_pkg::CrcInit;
      ones_q   <= '0;
      lvl_q    <= 1'b0;
      stuff_q  <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      bc_q     <= bc_d;
      crc_q    <= crc_d;
      ones_q   <= ones_d;
      lvl_q    <= lvl_d;
      stuff_q  <= stuff_d;
      ovalid_q <= ovalid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    line_q <= line_d;
    last_q <= last_d;
    fend_q <= fend_d;
  end

  assign out_valid_o = ovalid_q;
  assign line_bit_o  = line_q;
  assign run_last_o  = last_q;
  assign frame_end_o = fend_q;

  // checks
  `AHE_ASSERT(a_fend_is_last, clk_i, rst_ni, (out_valid_o && frame_end_o) |-> run_last_o)
  `AHE_ASSERT(a_stuff_in_coded, clk_i, rst_ni, stuff_q |-> (state_q == aishdlc_pkg::ST_DATA || state_q == aishdlc_pkg::ST_CRC))
  `AHE_ASSERT_ALWAYS(a_run_bound, clk_i, !rst_ni || (ones_q < 3'(aishdlc_pkg::StuffRun)))
  `AHE_ASSERT(a_frame_start, clk_i, rst_ni, (in_acc && bc_q == '0) |=> (state_q == aishdlc_pkg::ST_PRE))

endmodule

>>> tb/sv/tb_ais_hdlc_frame_encoder.sv
`timescale 1ns / 1ps

module tb_ais_hdlc_frame_encoder;

  localparam int unsigned PAYLOAD_BYTES  = aishdlc_pkg::PayloadBytesDef;
  localparam int unsigned DIR_ROWS       = 23;
  localparam int unsigned RAND_PER_PHASE = 170;
  localparam int unsigned LONG_HOLD      = 400;
  localparam int unsigned DRAIN_CYCLES   = 40;

  // one line bit as the block presents it
  typedef struct packed {
    logic line_bit;
    logic run_last;
    logic frame_end;
  } line_res_t;

  // directed request: byte, and optionally the line bits typed in, first bit highest
  typedef struct packed {
    logic [7:0]  data;
    logic [7:0]  typed_n;
    logic [63:0] typed_bits;
  } byte_row_t;

  localparam byte_row_t DIRECTED [DIR_ROWS] = '{
    // first byte after reset: preamble, then all zeros toggle the level
    '{8'h00, 8'd40, {24'd0, aishdlc_pkg::Preamble, 8'b1010_1010}},
    // five ones, a stuffed zero, three ones
    '{8'hFF, 8'd9, {55'd0, 9'b0_0000_1111}},
    '{8'h01, 8'd0, 64'd0},
    '{8'h80, 8'd0, 64'd0},
    '{8'h7E, 8'd0, 64'd0},
    '{8'hF8, 8'd0, 64'd0},
    '{8'h1F, 8'd0, 64'd0},
    '{8'h3E, 8'd0, 64'd0},
    '{8'h7C, 8'd0, 64'd0},
    '{8'h55, 8'd0, 64'd0},
    '{8'hAA, 8'd0, 64'd0},
    '{8'h0F, 8'd0, 64'd0},
    '{8'hF0, 8'd0, 64'd0},
    '{8'hFE, 8'd0, 64'd0},
    '{8'h7F, 8'd0, 64'd0},
    '{8'hFF, 8'd0, 64'd0},
    '{8'hFF, 8'd0, 64'd0},
    '{8'h00, 8'd0, 64'd0},
    '{8'hC3, 8'd0, 64'd0},
    '{8'h3C, 8'd0, 64'd0},
    // last byte of the frame: crc and end flag follow
    '{8'hE7, 8'd0, 64'd0},
    // new frame: preamble again, level and run count back at zero
    '{8'hFF, 8'd41, {23'd0, aishdlc_pkg::Preamble, 9'b0_0000_1111}},
    '{8'h00, 8'd0, 64'd0}
  };

  logic       clk_i          = 1'b0;
  logic       rst_ni         = 1'b0;
  logic       in_valid_i     = 1'b0;
  logic       in_stall_o;
  logic [7:0] payload_byte_i = 8'h00;
  logic       out_valid_o;
  logic       out_stall_i    = 1'b0;
  logic       line_bit_o;
  logic       run_last_o;
  logic       frame_end_o;

  // encoder state mirror
  logic [4:0]  frame_pos;
  logic [15:0] fcs_acc;
  logic [2:0]  ones_cnt;
  logic        line_level;

  line_res_t   step_out[$];
  line_res_t   bits_due[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic        hold_req      = 1'b0;
  int unsigned hold_left     = 0;
  int unsigned errors        = 0;
  int unsigned bytes_sent    = 0;
  int unsigned bits_seen     = 0;
  int unsigned frames_done   = 0;

  ais_hdlc_frame_encoder #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .payload_byte_i(payload_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .line_bit_o    (line_bit_o),
    .run_last_o    (run_last_o),
    .frame_end_o   (frame_end_o)
  );

  // 50 MHz clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // frame state back to its start
  function automatic void frame_restart();
    frame_pos  = '0;
    fcs_acc    = aishdlc_pkg::CrcInit;
    ones_cnt   = '0;
    line_level = 1'b0;
  endfunction

  function automatic void put_raw(input logic b);
    line_res_t r;
    r.line_bit  = b;
    r.run_last  = 1'b0;
    r.frame_end = 1'b0;
    step_out.push_back(r);
  endfunction

  // nrzi: zero toggles the level
  function automatic void put_coded(input logic b);
    if (!b) line_level = ~line_level;
    put_raw(line_level);
  endfunction

  // zero insertion after a run of ones
  function automatic void put_stuffed(input logic b);
    put_coded(b);
    ones_cnt = b ? ones_cnt + 3'd1 : 3'd0;
    if (ones_cnt >= aishdlc_pkg::StuffRun) begin
      put_coded(1'b0);
      ones_cnt = '0;
    end
  endfunction

  // line bits caused by one payload byte
  function automatic void encode_byte(input logic [7:0] b);
    int i;
    logic fb;
    logic [15:0] fcs;
    step_out.delete();
    if (frame_pos == 0) begin
      for (i = aishdlc_pkg::PreBits - 1; i >= 0; i--) put_raw(aishdlc_pkg::Preamble[i]);
    end
    for (i = 0; i < aishdlc_pkg::DataBits; i++) begin
      fb = fcs_acc[0] ^ b[i];
      fcs_acc = fcs_acc >> 1;
      if (fb) fcs_acc = fcs_acc ^ aishdlc_pkg::CrcPoly;
      put_stuffed(b[i]);
    end
    frame_pos = frame_pos + 5'd1;
    if (int'(frame_pos) >= PAYLOAD_BYTES) begin
      fcs = ~fcs_acc;
      for (i = 0; i < aishdlc_pkg::CrcBits; i++) put_stuffed(fcs[i]);
      for (i = aishdlc_pkg::FlagBits - 1; i >= 0; i--) put_raw(aishdlc_pkg::EndFlag[i]);
      step_out[step_out.size() - 1].frame_end = 1'b1;
      frames_done++;
      frame_restart();
    end
    step_out[step_out.size() - 1].run_last = 1'b1;
  endfunction

  // random byte, biased toward long runs of ones
  function automatic logic [7:0] rand_byte();
    unique case ($urandom_range(3))
      0:       return 8'hFF;
      1:       return 8'($urandom) | 8'($urandom);
      default: return 8'($urandom);
    endcase
  endfunction

  // offer one request and wait until it is taken
  task automatic send_byte(input logic [7:0] b, input logic [7:0] typed_n,
                           input logic [63:0] typed_bits);
    int unsigned i;
    line_res_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    payload_byte_i <= b;
    encode_byte(b);
    if (typed_n != 0) begin
      step_out.delete();
      for (i = typed_n; i > 0; i--) begin
        r.line_bit  = typed_bits[i-1];
        r.run_last  = (i == 1);
        r.frame_end = 1'b0;
        step_out.push_back(r);
      end
    end
    foreach (step_out[j]) bits_due.push_back(step_out[j]);
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    bytes_sent++;
  endtask

  // stop offering until every expected bit is out
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (bits_due.size() != 0) @(posedge clk_i);
  endtask

  // receiver stall, with one long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = LONG_HOLD - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // compare each line bit against the oldest expectation
  always @(posedge clk_i) begin
    line_res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (bits_due.size() == 0) begin
        $display("%0t: unexpected line bit: expected none, got bit %b last %b end %b",
                 $time, line_bit_o, run_last_o, frame_end_o);
        errors++;
      end else begin
        want = bits_due.pop_front();
        bits_seen++;
        if (line_bit_o !== want.line_bit) begin
          $display("%0t: line_bit expected %b got %b", $time, want.line_bit, line_bit_o);
          errors++;
        end
        if (run_last_o !== want.run_last) begin
          $display("%0t: run_last expected %b got %b", $time, want.run_last, run_last_o);
          errors++;
        end
        if (frame_end_o !== want.frame_end) begin
          $display("%0t: frame_end expected %b got %b", $time, want.frame_end, frame_end_o);
          errors++;
        end
      end
    end
  end

  // stimulus
  initial begin
    int unsigned k;
    int unsigned phase;
    frame_restart();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed table
    send_idle_pct = 31;
    recv_idle_pct = 45;
    for (k = 0; k < DIR_ROWS; k++) begin
      send_byte(DIRECTED[k].data, DIRECTED[k].typed_n, DIRECTED[k].typed_bits);
    end

    // random bytes in three idling phases
    for (phase = 0; phase < 3; phase++) begin
      wait_drained();
      case (phase)
        0: begin
          send_idle_pct = 31;
          recv_idle_pct = 45;
        end
        1: begin
          send_idle_pct = 45;
          recv_idle_pct = 31;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          hold_req      = 1'b1;
        end
      endcase
      for (k = 0; k < RAND_PER_PHASE; k++) send_byte(rand_byte(), 8'd0, 64'd0);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d payload bytes in %0d frames, %0d line bits checked",
             bytes_sent, frames_done, bits_seen);
    $display("stalls on both sides, one long receiver hold-off, %0d mismatches", errors);
    if (errors == 0 && bits_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/aishdlc_pkg.sv
rtl/ais_hdlc_frame_encoder.sv
tb/sv/tb_ais_hdlc_frame_encoder.sv
